[src/ioapic_rf_pkg.sv]
package ioapic_rf_pkg;

  // Default depth of the redirection word table
  localparam int DEFAULT_REDIRECT_WORDS = 48;

  // Bus offsets
  localparam logic [7:0] OFF_SELECT = 8'h00;
  localparam logic [7:0] OFF_WINDOW = 8'h10;

  // Select codes
  localparam logic [31:0] SEL_ID      = 32'h0000_0000;
  localparam logic [31:0] SEL_VERSION = 32'h0000_0001;
  localparam logic [31:0] SEL_ARB     = 32'h0000_0002;
  localparam logic [31:0] SEL_TABLE   = 32'h0000_0010;
  localparam logic [31:0] SEL_MAX     = 32'h0000_00FF;

  localparam logic [31:0] VERSION_CODE = 32'h0000_0011;

  // Function codes
  localparam logic FUNC_BUS    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_SELECT  = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ST_WRONG_DIR   = 2'd3;

  typedef struct packed {
    logic        func;
    logic        is_write;
    logic [7:0]  offset;
    logic [31:0] write_data;
    logic [4:0]  entry_index;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
    logic [7:0]  vector_out;
  } out_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

[src/ioapic_rf_table.sv]
module ioapic_rf_table
  import ioapic_rf_pkg::*;
#(
  parameter int WORDS = DEFAULT_REDIRECT_WORDS,
  parameter int AW    = $clog2(WORDS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data
);

  logic [31:0]      mem [WORDS];
  logic [WORDS-1:0] valid;
  logic [31:0]      rd_word;
  logic             rd_valid;

  // Write the word array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark written entries; reset makes every entry read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_word : 32'h0;

endmodule

[src/io_apic_register_file_core.sv]
// Indirect register window of an interrupt routing controller.
//
// Input channel in_valid/in_ready/in_data carries one transaction per item:
// a 32-bit bus access (func 0: select write at offset 0x00, window access at
// offset 0x10) or a redirect vector lookup (func 1). Output channel
// out_valid/out_ready/out_data returns exactly one result per item.
//
// An accepted item is held in the execute stage until the output register
// is free; no new item is accepted meanwhile. The redirection table sits in a
// single-port-read memory: the accept cycle issues the read, the execute
// cycle takes the read data, builds the result and writes back.
//
// Reset clears the select and ID registers and the per-entry valid bits of
// the table, so every table word reads as zero until written; there is no
// clearing pass and items are accepted right after reset.
//
// When the receiver stalls, the result holds in the output register. One
// more item is accepted and waits in the execute stage until the output
// register frees; further items wait at in_ready.
module io_apic_register_file_core
  import ioapic_rf_pkg::*;
#(
  parameter int REDIRECT_WORDS = DEFAULT_REDIRECT_WORDS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW = $clog2(REDIRECT_WORDS);
  localparam logic [31:0] WORDS_32 = 32'(REDIRECT_WORDS);
  localparam logic [31:0] VERSION_VAL =
    (32'((REDIRECT_WORDS / 2) - 1) << 16) | VERSION_CODE;

  state_t        state, state_next;
  in_t           cur;
  logic [AW-1:0] cur_addr;
  logic          lk_hit;
  logic          tbl_hit;
  logic [31:0]   select_reg;
  logic [31:0]   id_reg;
  out_t          res;
  logic          accept;
  logic          fire;
  logic          sel_we;
  logic          id_we;
  logic          tbl_we;
  logic [31:0]   tbl_rdata;
  logic [31:0]   lk_word;
  logic [31:0]   tbl_off;
  logic [31:0]   addr_full;
  logic          lk_hit_in;
  logic          tbl_hit_in;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    fire     = 1'b0;
    case (state)
      S_IDLE:  in_ready = 1'b1;
      S_EXEC:  fire     = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        fire     = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Compute the table address and range hits at accept
  always_comb begin
    lk_word    = 32'(in_data.entry_index) << 1;
    tbl_off    = select_reg - SEL_TABLE;
    lk_hit_in  = lk_word < WORDS_32;
    tbl_hit_in = (select_reg >= SEL_TABLE) && (tbl_off < WORDS_32);
    addr_full  = (in_data.func == FUNC_LOOKUP) ? lk_word : tbl_off;
  end

  // Hold the accepted transaction for the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cur      <= in_data;
      cur_addr <= addr_full[AW-1:0];
      lk_hit   <= lk_hit_in;
      tbl_hit  <= tbl_hit_in;
    end
  end

  ioapic_rf_table #(
    .WORDS (REDIRECT_WORDS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (addr_full[AW-1:0]),
    .rd_data (tbl_rdata),
    .wr_en   (tbl_we),
    .wr_addr (cur_addr),
    .wr_data (cur.write_data)
  );

  // Decode the transaction and build the result
  always_comb begin
    res    = '0;
    sel_we = 1'b0;
    id_we  = 1'b0;
    tbl_we = 1'b0;
    if (cur.func == FUNC_LOOKUP) begin
      if (lk_hit) begin
        res.vector_out = tbl_rdata[7:0];
      end else begin
        res.status = ST_UNSUPPORTED;
      end
    end else if (cur.offset == OFF_SELECT) begin
      if (!cur.is_write) begin
        res.status = ST_WRONG_DIR;
      end else begin
        sel_we     = fire;
        res.status = (cur.write_data > SEL_MAX) ? ST_BAD_SELECT : ST_OK;
      end
    end else if (cur.offset == OFF_WINDOW) begin
      if (select_reg == SEL_ID) begin
        if (cur.is_write) begin
          id_we = fire;
        end else begin
          res.read_data = id_reg;
        end
      end else if (select_reg == SEL_VERSION) begin
        if (cur.is_write) begin
          res.status = ST_WRONG_DIR;
        end else begin
          res.read_data = VERSION_VAL;
        end
      end else if (select_reg == SEL_ARB) begin
        if (cur.is_write) begin
          res.status = ST_WRONG_DIR;
        end
      end else if (tbl_hit) begin
        if (cur.is_write) begin
          tbl_we = fire;
        end else begin
          res.read_data = tbl_rdata;
        end
      end else begin
        res.status = ST_UNSUPPORTED;
      end
    end else begin
      res.status = ST_UNSUPPORTED;
    end
  end

  // Update the select and ID registers on write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      select_reg <= '0;
      id_reg     <= '0;
    end else begin
      if (sel_we) begin
        select_reg <= cur.write_data;
      end
      if (id_we) begin
        id_reg <= cur.write_data;
      end
    end
  end

  // Output register: load on fire, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

endmodule
